// ===== design/gbia_pkg.sv =====
// Shared types and codes for the grouped bitmap inode allocator.
package gbia_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_FORMAT = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_AGRP,
		S_ASCAN,
		S_FDIV,
		S_FRD,
		S_FWR,
		S_DONE
	} state_t;

	typedef enum logic {
		CFG_INODES_PER_GROUP = 1'b0,
		CFG_GROUP_COUNT      = 1'b1
	} cfg_idx_t;

	localparam int CFG_DATA_W = 9;
	localparam int NUM_W      = 12;
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	typedef struct packed {
		op_t        operation;
		logic [11:0] inode_number;
		logic [7:0]  groups_without_blocks;
	} gbia_req_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] allocated_number;
		logic [11:0] free_total;
	} gbia_rsp_t;

endpackage

// ===== design/grouped_bitmap_inode_allocator.sv =====
// Grouped bitmap inode allocator: sequencer, bitmap memory, counts and result register.
// Allocate skips each group whose count is zero or that is flagged without blocks, and scans
// the bytes of the others; free steps through the groups by subtraction, then reads and writes
// its byte; format clears the whole bitmap; operation three goes straight to the result.
// Throughput: one item at a time, bounded by the single bitmap read port (one byte a cycle).
// Reset: counts and registers load at once, then a clearing pass zeroes all
// MAX_GROUPS*MAX_PER_GROUP/8 bitmap bytes (256 by default) while no request is taken.
module grouped_bitmap_inode_allocator #(
	parameter int MAX_GROUPS    = 8,
	parameter int MAX_PER_GROUP = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  gbia_pkg::gbia_req_t           req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output gbia_pkg::gbia_rsp_t           rsp,
	input  logic                          cfg_we,
	input  gbia_pkg::cfg_idx_t            cfg_index,
	input  logic [gbia_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gbia_pkg::*;

	// Geometry: every group owns a fixed stretch of BPG bitmap bytes
	localparam int BPG       = MAX_PER_GROUP / 8;
	localparam int MAP       = MAX_GROUPS * BPG;
	localparam int AW        = (MAP > 1) ? $clog2(MAP) : 1;
	localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW       = $clog2(MAX_GROUPS + 1);
	localparam int PW        = $clog2(MAX_PER_GROUP + 1);
	localparam int BCW       = $clog2(BPG + 1);
	localparam int NW        = $clog2(MAX_GROUPS * MAX_PER_GROUP + 1);
	localparam int TW        = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
	localparam int CW        = (GCW > 4) ? GCW : 4;
	localparam int RESET_CNT = (MAX_PER_GROUP < 256) ? MAX_PER_GROUP : 256;
	localparam int RESET_GRP = (MAX_GROUPS < 8) ? MAX_GROUPS : 8;
	localparam int RESET_TOT = RESET_CNT * RESET_GRP;

	state_t              state_q, state_d;
	logic [8:0]          ipg_q;
	logic [3:0]          gc_q;
	logic [PW-1:0]       cnt_q [MAX_GROUPS];
	logic [NW-1:0]       total_q;
	logic [NW-1:0]       cap_q;
	logic [AW-1:0]       swp_addr_q;
	logic                fmt_q;
	logic                chk_vld_q;
	logic [7:0]          noblk_q;
	logic [GW-1:0]       g_q;
	logic [AW-1:0]       mbase_q;
	logic [NW-1:0]       nbase_q;
	logic [NUM_W-1:0]    rem_q;
	logic [BCW-1:0]      byte_q;
	logic [BCW-1:0]      chk_byte_q;
	logic [AW-1:0]       chk_addr_q;
	logic [7:0]          rdata_q;
	status_t             status_q;
	logic [NUM_W-1:0]    alloc_q;
	gbia_rsp_t           rsp_q;
	logic                rsp_valid_q;

	logic [7:0]          map_mem [MAP];

	logic [TW-1:0]       per_raw, per_clip;
	logic [CW-1:0]       grp_raw, grp_clip;
	logic [PW-1:0]       per_eff;
	logic [GCW-1:0]      grp_eff;
	logic [BCW-1:0]      nbytes;
	logic [BCW-1:0]      off_byte;
	logic [7:0]          noblk_sh;
	logic [2:0]          hit_bit;
	logic [NW-1:0]       alloc_d;

	logic                accept, slot_free;
	logic                hit, more, grp_last, skip, div_ge, swp_last;
	logic                adv, div_sub, scan_start, scan_issue, free_rd;
	logic                set_nospace, set_range, alloc_hit;
	logic                cnt_dec, cnt_inc, cnt_fill, rsp_load;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr, rd_addr;
	logic [7:0]          mem_wdata;

	// Effective register values: per_group drops its low three bits and is clamped, as is the group count
	always_comb begin
		per_raw = TW'({ipg_q[8:3], 3'b000});
		priority if (per_raw < TW'(8)) begin
			per_clip = TW'(8);
		end else if (per_raw > TW'(MAX_PER_GROUP)) begin
			per_clip = TW'(MAX_PER_GROUP);
		end else begin
			per_clip = per_raw;
		end
		per_eff = PW'(per_clip);

		grp_raw = CW'(gc_q);
		priority if (grp_raw < CW'(1)) begin
			grp_clip = CW'(1);
		end else if (grp_raw > CW'(MAX_GROUPS)) begin
			grp_clip = CW'(MAX_GROUPS);
		end else begin
			grp_clip = grp_raw;
		end
		grp_eff = GCW'(grp_clip);
	end

	assign nbytes   = BCW'(per_eff >> 3);
	assign off_byte = BCW'(rem_q >> 3);
	// Only the first eight groups have a no-free-blocks flag; the shift drops the rest
	assign noblk_sh = noblk_q >> g_q;

	// Lowest clear bit of the byte under test
	always_comb begin
		hit_bit = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (!rdata_q[i]) begin
				hit_bit = 3'(i);
			end
		end
	end

	assign alloc_d = nbase_q + NW'({chk_byte_q, hit_bit}) + NW'(1);

	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign hit       = chk_vld_q && (rdata_q != BYTE_FULL);
	assign more      = byte_q < nbytes;
	assign grp_last  = (GCW'(g_q) + GCW'(1)) == grp_eff;
	assign skip      = (cnt_q[g_q] == '0) || noblk_sh[0];
	assign div_ge    = rem_q >= per_eff;
	assign swp_last  = swp_addr_q == AW'(MAP - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (swp_last) begin
					state_d = fmt_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						OP_ALLOC:  state_d = S_AGRP;
						OP_FREE:   state_d = (req.inode_number == '0) ? S_DONE : S_FDIV;
						OP_FORMAT: state_d = S_SWEEP;
						OP_NOP:    state_d = S_DONE;
					endcase
				end
			end
			S_AGRP: begin
				if (!skip) begin
					state_d = S_ASCAN;
				end else if (grp_last) begin
					state_d = S_DONE;
				end
			end
			S_ASCAN: begin
				priority if (hit) begin
					state_d = S_DONE;
				end else if (more) begin
					state_d = S_ASCAN;
				end else begin
					state_d = grp_last ? S_DONE : S_AGRP;
				end
			end
			S_FDIV: begin
				if (!div_ge) begin
					state_d = S_FRD;
				end else if (grp_last) begin
					state_d = S_DONE;
				end
			end
			S_FRD: state_d = S_FWR;
			S_FWR: state_d = S_DONE;
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready   = 1'b0;
		adv         = 1'b0;
		div_sub     = 1'b0;
		scan_start  = 1'b0;
		scan_issue  = 1'b0;
		free_rd     = 1'b0;
		set_nospace = 1'b0;
		set_range   = 1'b0;
		alloc_hit   = 1'b0;
		cnt_dec     = 1'b0;
		cnt_inc     = 1'b0;
		cnt_fill    = 1'b0;
		rsp_load    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = chk_addr_q;
		mem_wdata   = rdata_q;
		rd_addr     = mbase_q + AW'(byte_q);
		unique case (state_q)
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = swp_addr_q;
				mem_wdata = '0;
				cnt_fill  = swp_last && fmt_q;
			end
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_AGRP: begin
				scan_start  = !skip;
				adv         = skip && !grp_last;
				set_nospace = skip && grp_last;
			end
			S_ASCAN: begin
				alloc_hit   = hit;
				cnt_dec     = hit;
				mem_we      = hit;
				mem_wdata   = rdata_q | (8'd1 << hit_bit);
				scan_issue  = !hit && more;
				adv         = !hit && !more && !grp_last;
				set_nospace = !hit && !more && grp_last;
			end
			S_FDIV: begin
				div_sub   = div_ge && !grp_last;
				adv       = div_ge && !grp_last;
				set_range = div_ge && grp_last;
			end
			S_FRD: begin
				rd_addr = mbase_q + AW'(off_byte);
				free_rd = 1'b1;
			end
			S_FWR: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q & ~(8'd1 << rem_q[2:0]);
				cnt_inc   = 1'b1;
			end
			S_DONE: begin
				rsp_load = slot_free;
			end
		endcase
	end

	// Bitmap store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= map_mem[rd_addr];
	end

	// Control state, registers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			ipg_q       <= 9'd256;
			gc_q        <= 4'd8;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				cnt_q[i] <= PW'(RESET_CNT);
			end
			total_q     <= NW'(RESET_TOT);
			swp_addr_q  <= '0;
			fmt_q       <= 1'b0;
			chk_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INODES_PER_GROUP: ipg_q <= cfg_wdata;
					CFG_GROUP_COUNT:      gc_q  <= cfg_wdata[3:0];
				endcase
			end

			// A taken format resets the sweep pointer to zero and starts a pass; it steps only while sweeping
			if (accept && req.operation == OP_FORMAT) begin
				swp_addr_q <= '0;
				fmt_q      <= 1'b1;
			end else if (state_q == S_SWEEP) begin
				swp_addr_q <= swp_addr_q + AW'(1);
			end

			if (scan_start) begin
				chk_vld_q <= 1'b0;
			end else if (scan_issue) begin
				chk_vld_q <= 1'b1;
			end

			if (cnt_fill) begin
				for (int i = 0; i < MAX_GROUPS; i++) begin
					cnt_q[i] <= per_eff;
				end
				total_q <= cap_q;
			end
			if (cnt_dec) begin
				cnt_q[g_q] <= cnt_q[g_q] - PW'(1);
				if (total_q != '0) begin
					total_q <= total_q - NW'(1);
				end
			end
			if (cnt_inc) begin
				if (cnt_q[g_q] < per_eff) begin
					cnt_q[g_q] <= cnt_q[g_q] + PW'(1);
				end
				if (total_q < cap_q) begin
					total_q <= total_q + NW'(1);
				end
			end

			// Output register: a waiting result does not stop the next request
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current request
	always_ff @(posedge clk) begin
		cap_q <= NW'(per_eff) * NW'(grp_eff);

		if (accept) begin
			noblk_q  <= req.groups_without_blocks;
			g_q      <= '0;
			mbase_q  <= '0;
			nbase_q  <= '0;
			rem_q    <= req.inode_number - NUM_W'(1);
			alloc_q  <= '0;
			status_q <= (req.operation == OP_FREE && req.inode_number == '0) ? ST_RANGE
				: ST_OK;
		end

		// Advance to the next group, stepping the byte and number bases with it
		if (adv) begin
			g_q     <= g_q + GW'(1);
			mbase_q <= mbase_q + AW'(BPG);
			nbase_q <= nbase_q + NW'(per_eff);
		end
		if (div_sub) begin
			rem_q <= rem_q - NUM_W'(per_eff);
		end

		if (scan_start) begin
			byte_q <= '0;
		end else if (scan_issue) begin
			byte_q     <= byte_q + BCW'(1);
			chk_byte_q <= byte_q;
			chk_addr_q <= rd_addr;
		end
		if (free_rd) begin
			chk_addr_q <= rd_addr;
		end

		if (set_nospace) begin
			status_q <= ST_NO_SPACE;
		end
		if (set_range) begin
			status_q <= ST_RANGE;
		end
		if (alloc_hit) begin
			alloc_q <= NUM_W'(alloc_d);
		end

		if (rsp_load) begin
			rsp_q.status           <= status_q;
			rsp_q.allocated_number <= alloc_q;
			rsp_q.free_total       <= NUM_W'(total_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An allocation never comes from a group whose count is already zero
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN && hit) |-> (cnt_q[g_q] != '0))
		else $error("allocation taken from an empty group");

	// The byte that yields a bit lies inside the group's active bytes
	a_hit_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN && hit) |-> (chk_byte_q < nbytes))
		else $error("allocation byte beyond the group");

	// A free reaches its write only with an offset inside the group
	a_free_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FWR) |-> (rem_q < per_eff))
		else $error("free offset not reduced below the group size");

	// A new result appears only out of the result state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the result state");

	// A taken request always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("request taken but sequencer stayed idle");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the grouped bitmap inode allocator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbia_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int MAX_GROUPS      = 8;
	localparam int MAX_PER_GROUP   = 256;
	localparam int BYTES_PER_GROUP = MAX_PER_GROUP / 8;
	localparam int MAP_BYTES       = MAX_GROUPS * BYTES_PER_GROUP;
	// Longest single operation is an allocate that scans every group.
	localparam int DRAIN_CYCLES    = 300;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int IDLE_PERCENT    = 21;
	localparam int RUN_LIMIT_NS    = 10_000_000;

	typedef struct {
		op_t         op;
		logic [11:0] number;
		logic [7:0]  no_blocks;
		bit          typed;
		gbia_rsp_t   want;
	} directed_row_t;

	typedef struct {
		logic [8:0] per_value;
		logic [8:0] count_value;
		int         items;
		bit         format_first;
	} phase_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	gbia_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	gbia_rsp_t rsp;
	logic      cfg_we    = 1'b0;
	cfg_idx_t  cfg_index = CFG_INODES_PER_GROUP;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Mirror of the allocator's state and registers.
	logic [7:0]  usage_map [MAP_BYTES];
	int unsigned grp_free [MAX_GROUPS];
	int unsigned total_free;
	logic [8:0]  per_group_reg;
	logic [3:0]  group_count_reg;

	gbia_rsp_t awaited_responses [$];
	logic [11:0] live_numbers [$];
	int  mismatch_count   = 0;
	bit  steady_flow      = 1'b0;
	bit  hold_off_request = 1'b0;

	grouped_bitmap_inode_allocator #(
		.MAX_GROUPS(MAX_GROUPS),
		.MAX_PER_GROUP(MAX_PER_GROUP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register values as the block uses them: low three bits dropped, then clamped.
	function automatic int unsigned per_group_in_use();
		int unsigned v;
		v = per_group_reg & ~9'd7;
		if (v < 8) v = 8;
		if (v > MAX_PER_GROUP) v = MAX_PER_GROUP;
		return v;
	endfunction

	function automatic int unsigned groups_in_use();
		int unsigned v;
		v = group_count_reg;
		if (v < 1) v = 1;
		if (v > MAX_GROUPS) v = MAX_GROUPS;
		return v;
	endfunction

	// Apply one operation to the mirrored state and return the response it yields.
	function automatic gbia_rsp_t predict_response(input gbia_req_t item);
		int unsigned per;
		int unsigned groups;
		int unsigned g;
		int unsigned b;
		int unsigned idx;
		int unsigned bit_pos;
		int unsigned off;
		int unsigned num;
		bit          found;
		gbia_rsp_t   out;
		per    = per_group_in_use();
		groups = groups_in_use();
		found  = 1'b0;
		out.status           = ST_OK;
		out.allocated_number = '0;
		case (item.operation)
			OP_ALLOC: begin
				// Skip groups with a zero count or flagged as out of data blocks.
				for (g = 0; g < groups && !found; g++) begin
					if (grp_free[g] != 0 && !item.groups_without_blocks[g]) begin
						for (b = 0; b < per / 8 && !found; b++) begin
							idx = g * BYTES_PER_GROUP + b;
							if (usage_map[idx] != BYTE_FULL) begin
								bit_pos = 0;
								while (bit_pos < 7 && usage_map[idx][bit_pos]) bit_pos++;
								usage_map[idx][bit_pos] = 1'b1;
								grp_free[g]--;
								if (total_free > 0) total_free--;
								out.allocated_number = 12'(g * per + b * 8 + bit_pos + 1);
								found = 1'b1;
							end
						end
					end
				end
				if (!found) out.status = ST_NO_SPACE;
			end
			OP_FREE: begin
				num = item.inode_number;
				if (num == 0 || (num - 1) / per >= groups) begin
					out.status = ST_RANGE;
				end else begin
					// Counts rise even when the bit was already clear, up to their limits.
					g   = (num - 1) / per;
					off = (num - 1) % per;
					usage_map[g * BYTES_PER_GROUP + off / 8][off % 8] = 1'b0;
					if (grp_free[g] < per) grp_free[g]++;
					if (total_free < per * groups) total_free++;
				end
			end
			OP_FORMAT: begin
				foreach (usage_map[i]) usage_map[i] = 8'h00;
				foreach (grp_free[i]) grp_free[i] = per;
				total_free = per * groups;
			end
			default: begin
			end
		endcase
		out.free_total = 12'(total_free);
		return out;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch %0d at %0t: %s got %0d, expected %0d",
			mismatch_count, $realtime, what, got, want);
	endtask

	// Offer one item, after a random gap unless the flow is steady, hold it until the transfer, then record its outcome.
	task automatic send_item(input gbia_req_t item, input bit typed, input gbia_rsp_t typed_rsp);
		gbia_rsp_t predicted;
		if (!steady_flow) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_ready !== 1'b1) @(posedge clk);
		predicted = predict_response(item);
		if (item.operation == OP_ALLOC && predicted.status == ST_OK)
			live_numbers.push_back(predicted.allocated_number);
		if (item.operation == OP_FORMAT) live_numbers.delete();
		awaited_responses.push_back(typed ? typed_rsp : predicted);
	endtask

	// Drop valid and wait until every outstanding response has been taken.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; the block is idle when this is called.
	task automatic write_config(input logic [8:0] per_value, input logic [8:0] count_value);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INODES_PER_GROUP;
		cfg_wdata <= per_value;
		@(posedge clk);
		cfg_index <= CFG_GROUP_COUNT;
		cfg_wdata <= count_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		per_group_reg   = per_value;
		group_count_reg = count_value[3:0];
		live_numbers.delete();
	endtask

	// Response side: check each transfer against the oldest expectation, then choose
	// ready for the next edge. A hold-off request keeps ready low for a counted stretch.
	initial begin
		int        hold_left;
		gbia_rsp_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready) begin
				if (awaited_responses.size() == 0) begin
					flag_mismatch("response with nothing pending, free_total",
						int'(rsp.free_total), 0);
				end else begin
					want = awaited_responses.pop_front();
					if (rsp.status !== want.status)
						flag_mismatch("status", int'(rsp.status), int'(want.status));
					if (rsp.allocated_number !== want.allocated_number)
						flag_mismatch("allocated_number", int'(rsp.allocated_number),
							int'(want.allocated_number));
					if (rsp.free_total !== want.free_total)
						flag_mismatch("free_total", int'(rsp.free_total),
							int'(want.free_total));
				end
			end
			if (hold_off_request) begin
				hold_left        = HOLD_OFF_CYCLES;
				hold_off_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Stimulus: directed table at the reset settings, then random phases under
	// several register settings, the out-of-range and extreme ones among them.
	initial begin
		directed_row_t directed_rows [21];
		phase_t        phases [9];
		gbia_req_t     item;
		gbia_rsp_t     want;
		int            roll;
		int            pick;
		int            idx;
		int unsigned   span;

		foreach (usage_map[i]) usage_map[i] = 8'h00;
		foreach (grp_free[i]) grp_free[i] = 256;
		total_free      = 2048;
		per_group_reg   = 9'd256;
		group_count_reg = 4'd8;

		directed_rows = '{
			'{OP_ALLOC,  12'd0,    8'h00, 1'b1, '{ST_OK,       12'd1,    12'd2047}},
			'{OP_ALLOC,  12'hFFF,  8'h00, 1'b1, '{ST_OK,       12'd2,    12'd2046}},
			'{OP_FREE,   12'd0,    8'h00, 1'b1, '{ST_RANGE,    12'd0,    12'd2046}},
			'{OP_FREE,   12'd2049, 8'hFF, 1'b1, '{ST_RANGE,    12'd0,    12'd2046}},
			'{OP_FREE,   12'hFFF,  8'h00, 1'b1, '{ST_RANGE,    12'd0,    12'd2046}},
			'{OP_FREE,   12'd1,    8'h00, 1'b1, '{ST_OK,       12'd0,    12'd2047}},
			// Release of an inode already free still raises the counts.
			'{OP_FREE,   12'd1,    8'h00, 1'b1, '{ST_OK,       12'd0,    12'd2048}},
			// Counts already at their ceiling stay put.
			'{OP_FREE,   12'd2048, 8'h00, 1'b1, '{ST_OK,       12'd0,    12'd2048}},
			'{OP_ALLOC,  12'd0,    8'hFF, 1'b1, '{ST_NO_SPACE, 12'd0,    12'd2048}},
			'{OP_ALLOC,  12'd0,    8'h7F, 1'b1, '{ST_OK,       12'd1793, 12'd2047}},
			'{OP_ALLOC,  12'd0,    8'h00, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_ALLOC,  12'd0,    8'h01, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_NOP,    12'hFFF,  8'hFF, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_FREE,   12'd1793, 8'h00, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_FORMAT, 12'd0,    8'h00, 1'b1, '{ST_OK,       12'd0,    12'd2048}},
			'{OP_ALLOC,  12'd0,    8'hFE, 1'b1, '{ST_OK,       12'd1,    12'd2047}},
			'{OP_ALLOC,  12'd0,    8'h00, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_FREE,   12'd256,  8'h00, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_FREE,   12'd257,  8'h00, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_ALLOC,  12'h555,  8'hAA, 1'b0, '{ST_OK,       12'd0,    12'd0}},
			'{OP_FORMAT, 12'hFFF,  8'hFF, 1'b1, '{ST_OK,       12'd0,    12'd2048}}
		};

		// Phase 0 runs at the reset settings; later ones rewrite both registers.
		phases = '{
			'{9'd256, 9'd8,  60, 1'b0},
			'{9'd8,   9'd1,  70, 1'b1},
			'{9'd0,   9'd0,  40, 1'b0},
			'{9'd16,  9'd3,  60, 1'b0},
			'{9'h1FF, 9'd15, 50, 1'b0},
			'{9'd13,  9'd9,  60, 1'b0},
			'{9'd256, 9'd8,  40, 1'b1},
			'{9'd40,  9'd5,  60, 1'b0},
			'{9'd0,   9'd0,  60, 1'b0}
		};
		phases[8].per_value   = 9'($urandom_range(0, 511));
		phases[8].count_value = 9'($urandom_range(0, 511));

		// Hold reset, then wait out the clearing pass until the block takes requests.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);

		foreach (directed_rows[r]) begin
			item.operation             = directed_rows[r].op;
			item.inode_number          = directed_rows[r].number;
			item.groups_without_blocks = directed_rows[r].no_blocks;
			send_item(item, directed_rows[r].typed, directed_rows[r].want);
		end

		want = '0;
		foreach (phases[p]) begin
			if (p != 0) begin
				drain_results();
				write_config(phases[p].per_value, phases[p].count_value);
			end
			// One whole phase runs with steady flow on both sides, apart from one response hold-off.
			steady_flow = (p == 3);
			for (int n = 0; n < phases[p].items; n++) begin
				// Stall the response side long enough that the request side backs up.
				if (p == 3 && n == 20) hold_off_request = 1'b1;
				// Pause the request side until nothing is outstanding.
				if (p == 5 && n == 30) drain_results();

				span = per_group_in_use() * groups_in_use();
				item.inode_number          = 12'($urandom_range(0, 4095));
				item.groups_without_blocks = 8'h00;
				roll = $urandom_range(0, 99);
				pick = $urandom_range(0, 99);
				if (phases[p].format_first && n == 0) begin
					item.operation = OP_FORMAT;
				end else if (roll < 45) begin
					item.operation = OP_ALLOC;
					if (pick >= 90)
						item.groups_without_blocks = 8'hFF;
					else if (pick >= 75)
						item.groups_without_blocks = 8'($urandom_range(0, 255));
					else if (pick >= 60)
						item.groups_without_blocks = 8'h01 << $urandom_range(0, 7);
				end else if (roll < 80) begin
					item.operation = OP_FREE;
					if (live_numbers.size() != 0 && pick < 70) begin
						idx = $urandom_range(0, live_numbers.size() - 1);
						item.inode_number = live_numbers[idx];
						live_numbers.delete(idx);
					end else if (pick < 78) begin
						item.inode_number = 12'd0;
					end else if (pick < 92) begin
						item.inode_number = 12'($urandom_range(1, span));
					end else begin
						item.inode_number = 12'($urandom_range(span + 1, 4095));
					end
				end else if (roll < 84) begin
					item.operation = OP_FORMAT;
				end else if (roll < 88) begin
					item.operation = OP_NOP;
				end else begin
					// Noise: every field fully random.
					item.operation             = op_t'($urandom_range(0, 3));
					item.groups_without_blocks = 8'($urandom_range(0, 255));
				end
				send_item(item, 1'b0, want);
			end
		end

		drain_results();
		// Give any stray response time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
design/gbia_pkg.sv
design/grouped_bitmap_inode_allocator.sv
verif/tb.sv
